/* rtl/ctrl_request_credit_seq_tracker_top_assert.svh */
// assertion macros for the credit and sequence tracker
`ifndef CTRL_REQUEST_CREDIT_SEQ_TRACKER_TOP_ASSERT_SVH
`define CTRL_REQUEST_CREDIT_SEQ_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTH
`define CRST_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CRST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CRST_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CRST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/crst_pkg.sv */
package crst_pkg;
   localparam int QueueDepthDefault = 64;
   localparam int SeqMod = 64;
   localparam int AsyncWords = 6;
   localparam int HdrWords = 2;
   localparam int EntryWidth = 36;

   localparam logic [1:0] EV_ADMIT = 2'd0;
   localparam logic [1:0] EV_REFUSE = 2'd1;
   localparam logic [1:0] EV_RETIRE = 2'd2;
   localparam logic [1:0] EV_IGNORE = 2'd3;

   localparam logic [1:0] RS_VALID = 2'd0;
   localparam logic [1:0] RS_DROPPED = 2'd1;
   localparam logic [1:0] RS_SIZE = 2'd2;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_RESERVE = 2'd1;
   localparam logic [1:0] CSR_FORCE = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  op_kind;
      logic [19:0] reg_address;
      logic [3:0]  word_count;
      logic        timed;
      logic        want_ack;
      logic [5:0]  ack_seq;
      logic [1:0]  ack_status;
      logic [31:0] ack_data;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [5:0]  seq;
      logic [3:0]  entry_op;
      logic [19:0] entry_address;
      logic [31:0] resp_data;
      logic [1:0]  retire_status;
      logic [1:0]  remote_status;
      logic        wanted;
      logic        last;
   } rsp_type;

   // queue entry: op, address, size, wanted, seq
   typedef struct packed {
      logic [3:0]  op;
      logic [19:0] addr;
      logic [4:0]  size;
      logic        wanted;
      logic [5:0]  seq;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request item
      logic decide;    // register admit / stale decisions
      logic push;      // write entry, emit admit
      logic refuse;    // emit refuse
      logic ignore;    // emit ignored ack
      logic pop;       // pop head and emit retire
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_ack;
      logic admit;
      logic stale;
      logic final_pop; // head popped next is the matched one
   } sts_type;
endpackage

/* rtl/ctrl_request_credit_seq_tracker_top.sv */
// channel   direction  handshake
// req_      in         accepted when start and not busy
// rsp_      out        one cycle per result, marked by rsp_valid
// csr_      in         written when csr_wr_en
// a request passes through accept, head read, decide and act
// an ack takes the same steps, plus a pop and a wait state per dropped entry retired before the match
// the queue ram read port paces the pop walk, one head read per retired entry
// reset is synchronous and clears control state; queue contents are undefined
// results cannot be stalled; busy stays high until the last result is issued
`include "ctrl_request_credit_seq_tracker_top_assert.svh"
module ctrl_request_credit_seq_tracker_top #(
   parameter int QueueDepth = crst_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  crst_pkg::req_type req_item,
   output logic              rsp_valid,
   output crst_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data
);
   import crst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   crst_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
   );

   crst_dp #(.QueueDepth(QueueDepth)) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wr_data(csr_wr_data), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   `CRST_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `CRST_ASSERT_IMPL(a_last_idle, clock, reset, rsp_valid && rsp_item.last, !busy)
   `CRST_ASSERT_IMPL(a_nonlast_retire, clock, reset, rsp_valid && !rsp_item.last,
                     rsp_item.event_res == EV_RETIRE && busy)
endmodule

/* rtl/crst_ram.sv */
module crst_ram #(
   parameter int Width = 36,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/crst_ctrl.sv */
module crst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  crst_pkg::sts_type sts,
   output crst_pkg::cmd_type cmd,
   output logic             busy
);
   import crst_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_HEAD, S_DECIDE, S_ACT, S_POP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      busy_in = busy_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in = 1'b1;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            // ram data valid now
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = S_ACT;
         end
         S_ACT: begin
            if (!sts.is_ack) begin
               cmd.push = sts.admit;
               cmd.refuse = !sts.admit;
               busy_in = 1'b0;
               state_in = S_IDLE;
            end else if (sts.stale) begin
               cmd.ignore = 1'b1;
               busy_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               cmd.pop = 1'b1;
               if (sts.final_pop) begin
                  busy_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            // wait for next head read
            state_in = S_ACT;
         end
         default: begin
            state_in = S_IDLE;
            busy_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;
endmodule

/* rtl/crst_dp.sv */
module crst_dp #(
   parameter int QueueDepth = crst_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  crst_pkg::req_type req_item,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data,
   input  crst_pkg::cmd_type cmd,
   output crst_pkg::sts_type sts,
   output logic              rsp_valid,
   output crst_pkg::rsp_type rsp_item
);
   import crst_pkg::*;

   localparam int Aw = $clog2(QueueDepth);
   localparam int Cw = $clog2(QueueDepth + 1);

   logic [15:0] cap_ff;
   logic [7:0]  res_ff;
   logic        force_ff;
   req_type     item_ff;
   logic [Aw-1:0] head_ff;
   logic [Cw-1:0] count_ff;
   logic [5:0]  nseq_ff;
   logic [16:0] occ_ff;
   logic [5:0]  remain_ff;
   logic        admit_ff, stale_ff;
   logic [4:0]  cost_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   entry_type   head_ent, wr_ent;
   logic [EntryWidth-1:0] rd_raw;
   logic [Aw-1:0] wr_addr, rd_addr, head_next;
   logic [Cw:0]   tail_sum;
   logic [4:0]  cost;
   logic [17:0] reserve;
   logic [17:0] limit;
   logic [17:0] need;
   logic [5:0]  diff;

   assign cost = 5'(HdrWords) + (item_ff.timed ? 5'd2 : 5'd0) + {1'b0, item_ff.word_count};
   assign reserve = 18'(res_ff) * 18'(AsyncWords);
   assign limit = ({2'b0, cap_ff} >= reserve) ? {2'b0, cap_ff} - reserve : 18'd0;
   assign need = {1'b0, occ_ff} + 18'(cost);
   assign head_ent = entry_type'(rd_raw);
   assign diff = item_ff.ack_seq - head_ent.seq;

   assign head_next = (32'(head_ff) == QueueDepth - 1) ? '0 : head_ff + 1'b1;
   assign tail_sum = (Cw + 1)'(head_ff) + (Cw + 1)'(count_ff);
   assign wr_addr = (tail_sum >= (Cw + 1)'(QueueDepth)) ?
                    Aw'(tail_sum - (Cw + 1)'(QueueDepth)) : Aw'(tail_sum);
   assign rd_addr = cmd.pop ? head_next : head_ff;

   assign wr_ent.op = item_ff.op_kind;
   assign wr_ent.addr = item_ff.reg_address;
   assign wr_ent.size = cost_ff;
   assign wr_ent.wanted = item_ff.want_ack | force_ff;
   assign wr_ent.seq = nseq_ff;

   crst_ram #(.Width(EntryWidth), .Depth(QueueDepth)) u_queue (
      .clock  (clock),
      .wr_en  (cmd.push),
      .wr_addr(wr_addr),
      .wr_data(wr_ent),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   assign sts.is_ack = item_ff.opcode;
   assign sts.admit = admit_ff;
   assign sts.stale = stale_ff;
   assign sts.final_pop = (remain_ff == 6'd0);

   always_comb begin
      rsp_in = '0;
      rsp_in.last = 1'b1;
      if (cmd.push) begin
         rsp_in.event_res = EV_ADMIT;
         rsp_in.seq = nseq_ff;
      end else if (cmd.refuse) begin
         rsp_in.event_res = EV_REFUSE;
         rsp_in.seq = nseq_ff;
      end else if (cmd.ignore) begin
         rsp_in.event_res = EV_IGNORE;
         rsp_in.seq = item_ff.ack_seq;
      end else if (cmd.pop) begin
         rsp_in.event_res = EV_RETIRE;
         rsp_in.seq = head_ent.seq;
         rsp_in.entry_op = head_ent.op;
         rsp_in.entry_address = head_ent.addr;
         if (remain_ff == 6'd0) begin
            rsp_in.resp_data = item_ff.ack_data;
            rsp_in.retire_status = (head_ent.size == cost_ff) ? RS_VALID : RS_SIZE;
            rsp_in.remote_status = item_ff.ack_status;
            rsp_in.wanted = head_ent.wanted && head_ent.op == item_ff.op_kind
                            && head_ent.addr == item_ff.reg_address;
         end else begin
            rsp_in.retire_status = RS_DROPPED;
            rsp_in.wanted = head_ent.wanted;
            rsp_in.last = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
      end
      if (cmd.decide) begin
         cost_ff <= cost;
         admit_ff <= (need <= limit) && (32'(count_ff) < QueueDepth);
         stale_ff <= (count_ff == '0) || diff[5] || (32'(diff) >= 32'(count_ff));
         remain_ff <= diff;
      end else if (cmd.pop) begin
         remain_ff <= remain_ff - 6'd1;
      end
      rsp_ff <= rsp_in;
      if (reset) begin
         cap_ff <= '0;
         res_ff <= '0;
         force_ff <= 1'b0;
         head_ff <= '0;
         count_ff <= '0;
         nseq_ff <= '0;
         occ_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.push | cmd.refuse | cmd.ignore | cmd.pop;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff <= csr_wr_data;
               CSR_RESERVE: res_ff <= csr_wr_data[7:0];
               CSR_FORCE: force_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
         if (cmd.push) begin
            count_ff <= count_ff + 1'b1;
            occ_ff <= need[16:0];
            nseq_ff <= nseq_ff + 6'd1;
         end else if (cmd.pop) begin
            count_ff <= count_ff - 1'b1;
            head_ff <= head_next;
            occ_ff <= (occ_ff >= 17'(head_ent.size)) ? occ_ff - 17'(head_ent.size) : '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;
endmodule

/* verif/crst_tracker_checker.sv */
`timescale 1ns / 100ps
module crst_tracker_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  crst_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  crst_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data,
   output int                pending,
   output int                fail_count
);
   import crst_pkg::*;

   localparam int Depth = QueueDepthDefault;
   localparam int ExpDepth = 64;

   logic [15:0] capacity_words;
   logic [7:0]  reserve_msgs;
   logic        force_ack;

   entry_type   tracked [Depth];
   int unsigned head_idx;
   int unsigned entry_cnt;
   logic [5:0]  seq_next;
   int unsigned used_words;

   // expected results, oldest at exp_rd
   rsp_type     exp_ring [ExpDepth];
   int unsigned exp_rd = 0;
   int unsigned exp_cnt = 0;

   assign pending = int'(exp_cnt);

   function automatic rsp_type blank_event(logic [1:0] ev, logic [5:0] s);
      rsp_type r;
      r = '0;
      r.event_res = ev;
      r.seq = s;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic note_event(input rsp_type r);
      exp_ring[(exp_rd + exp_cnt) % ExpDepth] = r;
      exp_cnt++;
   endtask

   task automatic take_event(output rsp_type r);
      r = exp_ring[exp_rd];
      exp_rd = (exp_rd + 1) % ExpDepth;
      exp_cnt--;
   endtask

   task automatic retire_head(output entry_type e);
      e = tracked[head_idx];
      used_words = (used_words >= e.size) ? used_words - e.size : 0;
      head_idx = (head_idx + 1) % Depth;
      entry_cnt--;
   endtask

   task automatic predict_events(input req_type r);
      int unsigned cost, reserve, limit, diff;
      entry_type e;
      rsp_type o;
      cost = HdrWords + (r.timed ? 2 : 0) + r.word_count;
      if (!r.opcode) begin
         reserve = AsyncWords * reserve_msgs;
         limit = (capacity_words >= reserve) ? capacity_words - reserve : 0;
         if (used_words + cost > limit || entry_cnt >= Depth) begin
            note_event(blank_event(EV_REFUSE, seq_next));
         end else begin
            e.op = r.op_kind;
            e.addr = r.reg_address;
            e.size = 5'(cost);
            e.wanted = r.want_ack | force_ack;
            e.seq = seq_next;
            tracked[(head_idx + entry_cnt) % Depth] = e;
            entry_cnt++;
            used_words += cost;
            note_event(blank_event(EV_ADMIT, seq_next));
            seq_next = seq_next + 1'b1;
         end
      end else begin
         diff = (entry_cnt == 0) ? 0 : 6'(r.ack_seq - tracked[head_idx].seq);
         if (entry_cnt == 0 || diff >= 32 || diff >= entry_cnt) begin
            note_event(blank_event(EV_IGNORE, r.ack_seq));
         end else begin
            // skipped entries retire as dropped before the matched one
            for (int k = 0; k <= diff; k++) begin
               retire_head(e);
               o = '0;
               o.event_res = EV_RETIRE;
               o.seq = e.seq;
               o.entry_op = e.op;
               o.entry_address = e.addr;
               if (k < diff) begin
                  o.retire_status = RS_DROPPED;
                  o.wanted = e.wanted;
               end else begin
                  o.resp_data = r.ack_data;
                  o.retire_status = (e.size == cost) ? RS_VALID : RS_SIZE;
                  o.remote_status = r.ack_status;
                  o.wanted = e.wanted && e.op == r.op_kind && e.addr == r.reg_address;
                  o.last = 1'b1;
               end
               note_event(o);
            end
         end
      end
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         capacity_words = '0;
         reserve_msgs = '0;
         force_ack = 1'b0;
         head_idx = 0;
         entry_cnt = 0;
         seq_next = '0;
         used_words = 0;
         exp_rd = 0;
         exp_cnt = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CAPACITY: capacity_words = csr_wr_data;
               CSR_RESERVE: reserve_msgs = csr_wr_data[7:0];
               CSR_FORCE: force_ack = csr_wr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) predict_events(req_item);
         if (rsp_valid) begin
            if (exp_cnt == 0) begin
               $error("unexpected transaction: event_res %0d seq %0d",
                      rsp_item.event_res, rsp_item.seq);
               fail_count++;
            end else begin
               take_event(e);
               check_field("event_res", e.event_res, rsp_item.event_res);
               check_field("seq", e.seq, rsp_item.seq);
               check_field("entry_op", e.entry_op, rsp_item.entry_op);
               check_field("entry_address", e.entry_address, rsp_item.entry_address);
               check_field("resp_data", e.resp_data, rsp_item.resp_data);
               check_field("retire_status", e.retire_status, rsp_item.retire_status);
               check_field("remote_status", e.remote_status, rsp_item.remote_status);
               check_field("wanted", e.wanted, rsp_item.wanted);
               check_field("last", e.last, rsp_item.last);
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

/* verif/tb_ctrl_request_credit_seq_tracker_top.sv */
`timescale 1ns / 100ps
module tb_ctrl_request_credit_seq_tracker_top;
   import crst_pkg::*;

   localparam logic OP_ISSUE = 1'b0;
   localparam logic OP_ACK = 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_CAPACITY;
   logic [15:0] csr_wr_data = '0;
   int          pending;
   int          fail_count;

   // requests seen admitted, indexed by seq, and the seqs still in flight
   req_type     admitted_req [64];
   logic [5:0]  open_ring [64];
   int unsigned open_head = 0;
   int unsigned open_cnt = 0;
   req_type     last_sent;
   bit          no_gaps;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ctrl_request_credit_seq_tracker_top i_dut (
      .clock, .reset, .start, .busy, .req_item,
      .rsp_valid, .rsp_item, .csr_wr_en, .csr_index, .csr_wr_data
   );

   crst_tracker_checker i_checker (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .csr_wr_en, .csr_index, .csr_wr_data, .pending, .fail_count
   );

   function automatic logic [5:0] open_seq(int k);
      return open_ring[(open_head + k) % 64];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_item.event_res == EV_ADMIT) begin
            admitted_req[rsp_item.seq] = last_sent;
            open_ring[(open_head + open_cnt) % 64] = rsp_item.seq;
            open_cnt++;
         end else if (rsp_item.event_res == EV_RETIRE && open_cnt > 0) begin
            open_head = (open_head + 1) % 64;
            open_cnt--;
         end
      end
      if (!reset && start && !busy) last_sent = req_item;
   end

   task automatic send(input req_type r);
      int gap;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic req_type random_issue();
      req_type r;
      r = req_type'(71'({$urandom, $urandom, $urandom}));
      r.opcode = OP_ISSUE;
      r.word_count = $urandom_range(1, 15);
      return r;
   endfunction

   // ack mostly aimed at an in-flight entry near the head
   function automatic req_type random_ack();
      req_type r;
      req_type src;
      int k;
      r = req_type'(71'({$urandom, $urandom, $urandom}));
      r.opcode = OP_ACK;
      r.word_count = $urandom_range(1, 15);
      if (open_cnt > 0 && $urandom_range(0, 7) != 0) begin
         k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, open_cnt - 1)
                                          : $urandom_range(0, (open_cnt > 3)
                                                           ? 3 : open_cnt - 1);
         r.ack_seq = open_seq(k);
         src = admitted_req[r.ack_seq];
         if ($urandom_range(0, 3) != 0) begin
            r.word_count = src.word_count;
            r.timed = src.timed;
         end
         if ($urandom_range(0, 3) != 0) begin
            r.op_kind = src.op_kind;
            r.reg_address = src.reg_address;
         end
      end
      return r;
   endfunction

   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] cap, input logic [7:0] res, input logic frc);
      settle();
      write_csr(CSR_CAPACITY, cap);
      write_csr(CSR_RESERVE, {8'h00, res});
      write_csr(CSR_FORCE, {15'd0, frc});
   endtask

   task automatic run_phase(input int n, input int ack_pct);
      for (int i = 0; i < n; i++)
         send(($urandom_range(0, 99) < ack_pct) ? random_ack() : random_issue());
   endtask

   initial begin
      req_type r;
      no_gaps = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero capacity refuses, empty queue ignores acks
      send(random_issue());
      send(random_ack());
      configure(16'd100, 8'd0, 1'b0);
      r = random_issue(); r.word_count = 4'd1; r.timed = 1'b0; r.want_ack = 1'b1;
      send(r);
      r = random_issue(); r.word_count = 4'd15; r.timed = 1'b1; r.want_ack = 1'b0;
      send(r);
      for (int i = 0; i < 4; i++) send(random_issue());
      settle();
      // skip two entries so they retire as dropped
      r = admitted_req[open_seq(2)];
      r.opcode = OP_ACK; r.ack_seq = open_seq(2); r.ack_status = 2'd3;
      r.ack_data = 32'hffff_ffff;
      send(r);
      settle();
      // size mismatch on the head
      r = admitted_req[open_seq(0)];
      r.opcode = OP_ACK; r.ack_seq = open_seq(0);
      r.timed = ~r.timed;
      send(r);
      settle();
      // stale ack behind the head, and one beyond the queue
      r = random_ack(); r.ack_seq = open_seq(0) - 6'd1; send(r);
      r = random_ack(); r.ack_seq = open_seq(0) + 6'd20; send(r);
      // reserve larger than capacity
      configure(16'd100, 8'd255, 1'b1);
      send(random_issue());
      send(random_ack());

      // fill the queue with credit to spare
      configure(16'hffff, 8'd0, 1'b1);
      no_gaps = 1'b1;
      run_phase(75, 5);
      no_gaps = 1'b0;
      run_phase(60, 70);
      configure(16'd120, 8'd3, 1'b0);
      run_phase(80, 45);
      configure(16'd40, 8'd0, 1'b1);
      no_gaps = 1'b1;
      run_phase(40, 50);
      no_gaps = 1'b0;
      configure(16'd0, 8'd0, 1'b0);
      run_phase(10, 50);
      configure(16'd1600, 8'd255, 1'b0);
      run_phase(10, 30);
      configure(16'd2000, 8'd100, 1'b1);
      run_phase(90, 40);

      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("** ctrl_request_credit_seq_tracker_top: PASSED **");
      end else begin
         $display("** ctrl_request_credit_seq_tracker_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("** ctrl_request_credit_seq_tracker_top: FAILED **");
      $finish;
   end
endmodule
